FILE: hdl/dics_pkg.sv
package dics_pkg;

  // Field widths of the request and result channels.
  localparam int ValueW = 33;
  localparam int DistW  = 4;
  localparam int ClassW = 4;
  localparam int CountW = 5;

  // Default table geometry.
  localparam int MaxClassesDef = 16;
  localparam int MaxDistsDef   = 16;

  // Class count after reset.
  localparam logic [CountW-1:0] NumClassesRst = 5'd16;

  // Depths of the command queue and the result queue.
  localparam int CmdQDepth = 2;
  localparam int ResQDepth = 2;

  // Request command codes.
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Operations that the front end hands to the back end.
  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpSearch = 2'd1,
    OpDirect = 2'd2
  } op_e;

  // One queued command.
  typedef struct packed {
    op_e               op;
    logic [DistW-1:0]  dist_idx;
    logic [ClassW-1:0] cls;
    logic [ValueW-1:0] value;
  } cmd_t;

endpackage

FILE: hdl/dics_fifo.sv
module dics_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update, wrapping at any depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/dics_front.sv
module dics_front #(
  parameter int MAX_CLASSES = dics_pkg::MaxClassesDef,
  parameter int MAX_DISTS   = dics_pkg::MaxDistsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dics_pkg::CountW-1:0] k_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        cmd_i,
  input  logic [dics_pkg::DistW-1:0]  dist_index_i,
  input  logic [dics_pkg::ClassW-1:0] class_index_i,
  input  logic [dics_pkg::ValueW-1:0] value_i,
  input  logic                        cq_pop_i,
  output dics_pkg::cmd_t              cq_data_o,
  output logic                        cq_empty_o
);

  import dics_pkg::*;

  logic dist_ok, cls_ok, enq;
  cmd_t entry;

  // Range checks on the request indexes.
  assign dist_ok = (int'(dist_index_i) < MAX_DISTS);
  assign cls_ok  = (int'(class_index_i) < MAX_CLASSES);

  // Classify the request. A sample that cannot hit any edge is answered
  // directly with the class count; loads outside the table are dropped.
  always_comb begin
    entry.dist_idx = dist_index_i;
    entry.cls      = class_index_i;
    entry.value    = value_i;
    if (cmd_i == CmdLoad) begin
      entry.op = OpLoad;
    end else if (dist_ok && (k_i != '0)) begin
      entry.op = OpSearch;
    end else begin
      entry.op = OpDirect;
    end
    enq = push_i && ((cmd_i == CmdSample) || (dist_ok && cls_ok));
  end

  dics_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CmdQDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (entry),
    .full_o  (full_o),
    .pop_i   (cq_pop_i),
    .data_o  (cq_data_o),
    .empty_o (cq_empty_o)
  );

endmodule

FILE: hdl/dics_back.sv
module dics_back #(
  parameter int MAX_CLASSES = dics_pkg::MaxClassesDef,
  parameter int MAX_DISTS   = dics_pkg::MaxDistsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dics_pkg::CountW-1:0] k_i,
  input  dics_pkg::cmd_t              cq_data_i,
  input  logic                        cq_empty_i,
  output logic                        cq_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [dics_pkg::CountW-1:0] sample_class_o
);

  import dics_pkg::*;

  localparam int Depth = MAX_CLASSES * MAX_DISTS;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSearch = 3'b010,
    StResult = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]  base_q, base_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [CountW-1:0] rd_idx_q, rd_idx_d;
  logic [CountW-1:0] cmp_idx_q, cmp_idx_d;
  logic [CountW-1:0] result_q, result_d;
  logic [ValueW-1:0] rdata_q;

  logic [ValueW-1:0] mem [Depth];

  logic              mem_we, issue, found;
  logic [AddrW-1:0]  waddr, raddr, head_base;
  logic [CountW-1:0] found_cls;
  logic              res_push, res_full;
  logic [CountW-1:0] res_data;

  // Table addresses for the queue head and for the running search.
  assign head_base = AddrW'(int'(cq_data_i.dist_idx) * MAX_CLASSES);
  assign waddr     = AddrW'(int'(cq_data_i.dist_idx) * MAX_CLASSES + int'(cq_data_i.cls));
  assign raddr     = base_q + AddrW'(rd_idx_q);

  // Compare the edge read last cycle against the sample value.
  always_comb begin
    found     = 1'b0;
    found_cls = cmp_idx_q;
    if ((state_q == StSearch) && rd_vld_q) begin
      if (value_q <= rdata_q) begin
        found = 1'b1;
      end else if (({1'b0, cmp_idx_q} + (CountW + 1)'(1)) == {1'b0, k_i}) begin
        found     = 1'b1;
        found_cls = k_i;
      end
    end
  end

  assign issue = (state_q == StSearch) && (rd_idx_q < k_i) && !found;

  // Sequencer: one queued command at a time, one table edge per cycle.
  always_comb begin
    state_d   = state_q;
    rd_vld_d  = 1'b0;
    base_d    = base_q;
    value_d   = value_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    result_d  = result_q;
    cq_pop_o  = 1'b0;
    mem_we    = 1'b0;
    res_push  = 1'b0;
    res_data  = result_q;
    case (state_q)
      StIdle: begin
        if (!cq_empty_i) begin
          case (cq_data_i.op)
            OpLoad: begin
              mem_we   = 1'b1;
              cq_pop_o = 1'b1;
            end
            OpSearch: begin
              cq_pop_o = 1'b1;
              base_d   = head_base;
              value_d  = cq_data_i.value;
              rd_idx_d = '0;
              state_d  = StSearch;
            end
            OpDirect: begin
              if (!res_full) begin
                res_push = 1'b1;
                res_data = k_i;
                cq_pop_o = 1'b1;
              end
            end
            default: begin
              cq_pop_o = 1'b1;
            end
          endcase
        end
      end
      StSearch: begin
        if (issue) begin
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q;
          rd_idx_d  = rd_idx_q + CountW'(1);
        end
        if (found) begin
          result_d = found_cls;
          state_d  = StResult;
        end
      end
      StResult: begin
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    value_q   <= value_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    result_q  <= result_d;
  end

  // Edge table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= cq_data_i.value;
    end
    if (issue) begin
      rdata_q <= mem[raddr];
    end
  end

  dics_fifo #(
    .WIDTH (CountW),
    .DEPTH (ResQDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (sample_class_o),
    .empty_o (empty_o)
  );

endmodule

FILE: hdl/discrete_inverse_cdf_sampler.sv
// Discrete inverse-CDF sampler.
// Requests enter through a queue interface: a request is taken at a clock
// edge with push high and full low. A load request (cmd 0) writes one
// cumulative edge; a sample request (cmd 1) returns the first class whose
// edge is not below the value, or the class count if none is.
// Results leave through a queue interface: sample_class_o is valid while
// empty is low and is taken at a clock edge with pop high.
// The class count is written over the config channel (cfg_valid_i and
// cfg_ready_o, always ready); the user must write it only while no
// request is in flight, since the block itself does not enforce this.
// A sample searches the edges of its distribution in class order, since
// the edge table has a single read port and the search reads one edge per
// cycle; a sample that needs no search (distribution out of range or a
// class count of zero) is answered directly with the class count. Each
// queue shows an entry in the cycle after it is written.
// A two-entry command queue lets requests arrive while a search runs, and a
// two-entry result queue lets the back end finish while the receiver
// stalls; when the command queue fills, full rises and requests wait.
// Reset empties both queues and sets the class count to 16; the edge table
// is not cleared and must be loaded before it is sampled.
module discrete_inverse_cdf_sampler #(
  parameter int MAX_CLASSES = dics_pkg::MaxClassesDef,
  parameter int MAX_DISTS   = dics_pkg::MaxDistsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd_i,
  input  logic [dics_pkg::DistW-1:0]  dist_index_i,
  input  logic [dics_pkg::ClassW-1:0] class_index_i,
  input  logic [dics_pkg::ValueW-1:0] value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [dics_pkg::CountW-1:0] sample_class_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dics_pkg::CountW-1:0] cfg_data_i
);

  import dics_pkg::*;

  logic [CountW-1:0] num_classes_q;
  logic [CountW-1:0] k;
  cmd_t              cq_data;
  logic              cq_empty, cq_pop;

  // Class count register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= NumClassesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_classes_q <= cfg_data_i;
    end
  end

  // Effective class count saturates at the table row length.
  assign k = (int'(num_classes_q) > MAX_CLASSES) ? CountW'(MAX_CLASSES) : num_classes_q;

  dics_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_DISTS   (MAX_DISTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .k_i           (k),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .dist_index_i  (dist_index_i),
    .class_index_i (class_index_i),
    .value_i       (value_i),
    .cq_pop_i      (cq_pop),
    .cq_data_o     (cq_data),
    .cq_empty_o    (cq_empty)
  );

  dics_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_DISTS   (MAX_DISTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .k_i            (k),
    .cq_data_i      (cq_data),
    .cq_empty_i     (cq_empty),
    .cq_pop_o       (cq_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .sample_class_o (sample_class_o)
  );

  // The back end only takes commands that the queue actually holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cq_pop |-> !cq_empty)
    else $error("back end popped an empty command queue");

  // Coming out of reset, both queues are empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (empty && !full && cq_empty))
    else $error("queues not empty after reset");

endmodule

FILE: tb/sv/discrete_inverse_cdf_sampler_test.sv
module discrete_inverse_cdf_sampler_test;
  import dics_pkg::*;

  localparam logic [ValueW-1:0] One      = 33'h1_0000_0000;
  localparam logic [ValueW-1:0] ValueMax = '1;
  // Cycles to let queued loads drain before the class count changes.
  localparam int SettleCycles = 32;
  localparam int TailCycles   = 40;
  localparam int PhaseItems   = 200;

  // Ways to fill one distribution's table.
  typedef enum int {
    ShapeRamp,
    ShapeSorted,
    ShapeFlat,
    ShapeScrambled
  } cdf_shape_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 push          = 1'b0;
  logic                 full;
  logic                 cmd_i         = CmdLoad;
  logic [DistW-1:0]     dist_index_i  = '0;
  logic [ClassW-1:0]    class_index_i = '0;
  logic [ValueW-1:0]    value_i       = '0;
  logic                 empty;
  logic                 pop           = 1'b0;
  logic [CountW-1:0]    sample_class_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CountW-1:0]    cfg_data_i    = '0;

  // Shadow copy of the edge tables and the class count.
  logic [ValueW-1:0]    cdf_edges [MaxDistsDef][MaxClassesDef];
  logic [CountW-1:0]    class_count_q = NumClassesRst;
  logic [CountW-1:0]    drawn_class_q [$];

  bit                   steady = 1'b0;
  int                   errors = 0;
  int                   samples_checked = 0;
  int                   loads_sent = 0;
  int                   counts_written = 0;

  discrete_inverse_cdf_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .dist_index_i   (dist_index_i),
    .class_index_i  (class_index_i),
    .value_i        (value_i),
    .empty          (empty),
    .pop            (pop),
    .sample_class_o (sample_class_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Print one mismatch line and count it; stop printing after many.
  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    errors++;
  endtask

  // Random idle decision shared by both sides.
  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 28);
  endfunction

  // Inverse-transform search over the shadow table.
  function automatic logic [CountW-1:0] draw_class(input logic [DistW-1:0] d,
                                                   input logic [ValueW-1:0] u);
    int k;
    int c;
    k = (class_count_q > MaxClassesDef) ? MaxClassesDef : int'(class_count_q);
    c = 0;
    while (c < k && u > cdf_edges[d][c]) begin
      c++;
    end
    return CountW'(c);
  endfunction

  // A probe value near one of the distribution's edges, an extreme, or a random value.
  function automatic logic [ValueW-1:0] pick_probe(input logic [DistW-1:0] d);
    logic [ValueW-1:0] e;
    e = cdf_edges[d][$urandom_range(0, MaxClassesDef - 1)];
    case ($urandom_range(0, 7))
      0: return e;
      1: return e + 1'b1;
      2: return e - 1'b1;
      3: return '0;
      4: return One;
      5: return ValueMax;
      6: return {1'b0, $urandom()};
      default: return {1'($urandom_range(0, 1)), $urandom()};
    endcase
  endfunction

  // Send one request and update the shadow state once it is taken.
  task automatic send_request(input logic c, input logic [DistW-1:0] d,
                              input logic [ClassW-1:0] k, input logic [ValueW-1:0] v);
    while (take_break()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    cmd_i         <= c;
    dist_index_i  <= d;
    class_index_i <= k;
    value_i       <= v;
    do @(posedge clk_i); while (full);
    if (c == CmdLoad) begin
      cdf_edges[d][k] = v;
      loads_sent++;
    end else begin
      drawn_class_q.push_back(draw_class(d, v));
    end
  endtask

  // Write all edges of one distribution.
  task automatic load_cdf(input logic [DistW-1:0] d, input cdf_shape_e shape);
    logic [ValueW-1:0] acc;
    logic [ValueW-1:0] flat;
    logic [ValueW-1:0] edge_v;
    int c;
    acc = '0;
    case ($urandom_range(0, 3))
      0: flat = '0;
      1: flat = One;
      2: flat = ValueMax;
      default: flat = {1'b0, $urandom()};
    endcase
    for (c = 0; c < MaxClassesDef; c++) begin
      case (shape)
        ShapeRamp: edge_v = ValueW'(c + 1) << 28;
        ShapeSorted: begin
          // About a quarter of the steps are zero, which gives tied edges.
          if ($urandom_range(0, 3) != 0) begin
            acc = acc + $urandom_range(0, 32'h1000_0000);
          end
          edge_v = (c == MaxClassesDef - 1) ? One : acc;
        end
        ShapeFlat: edge_v = flat;
        default: edge_v = {1'($urandom_range(0, 1)), $urandom()};
      endcase
      send_request(CmdLoad, d, ClassW'(c), edge_v);
    end
  endtask

  // Change the class count once every request has been served.
  task automatic write_class_count(input logic [CountW-1:0] n);
    push <= 1'b0;
    while (drawn_class_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    class_count_q = n;
    counts_written++;
  endtask

  // Every table entry is written before the first sample reads it.
  task automatic test_fill_tables();
    int d;
    load_cdf(DistW'(0), ShapeRamp);
    load_cdf(DistW'(MaxDistsDef - 1), ShapeSorted);
    for (d = 1; d < MaxDistsDef - 1; d++) begin
      case ($urandom_range(0, 3))
        0, 1: load_cdf(DistW'(d), ShapeSorted);
        2: load_cdf(DistW'(d), ShapeFlat);
        default: load_cdf(DistW'(d), ShapeScrambled);
      endcase
    end
  endtask

  // Values at, just around and beyond the edges under the reset class count.
  task automatic test_edge_values();
    logic [DistW-1:0] top;
    top = DistW'(MaxDistsDef - 1);
    send_request(CmdSample, '0, 4'($urandom()), '0);
    send_request(CmdSample, '0, 4'($urandom()), ValueW'(1) << 28);
    send_request(CmdSample, '0, 4'($urandom()), (ValueW'(1) << 28) + 1'b1);
    send_request(CmdSample, '0, 4'($urandom()), One);
    send_request(CmdSample, '0, 4'($urandom()), One + 1'b1);
    send_request(CmdSample, '0, 4'($urandom()), ValueMax);
    send_request(CmdSample, top, 4'($urandom()), '0);
    send_request(CmdSample, top, 4'($urandom()), ValueMax);
    send_request(CmdLoad, top, 4'hf, ValueMax);
    send_request(CmdLoad, top, 4'h0, '0);
    send_request(CmdSample, top, 4'($urandom()), ValueMax);
    send_request(CmdSample, top, 4'($urandom()), '0);
    send_request(CmdSample, top, 4'($urandom()), 33'h1);
    send_request(CmdLoad, '0, 4'hf, ValueMax);
    send_request(CmdSample, '0, 4'($urandom()), ValueMax);
    send_request(CmdLoad, '0, 4'hf, One);
    send_request(CmdSample, '0, 4'($urandom()), ValueMax);
    send_request(CmdSample, 4'h1, 4'($urandom()), One);
    send_request(CmdSample, 4'h7, 4'($urandom()), {1'b0, $urandom()});
  endtask

  // Class counts of zero, one, the maximum and above it, and in between.
  task automatic test_class_counts();
    logic [CountW-1:0] counts [7] = '{5'd1, 5'd0, 5'd17, 5'd31, 5'd2, 5'd15, 5'd16};
    logic [DistW-1:0] d;
    int i;
    int j;
    for (i = 0; i < 7; i++) begin
      write_class_count(counts[i]);
      for (j = 0; j < 24; j++) begin
        d = 4'($urandom());
        if ($urandom_range(0, 5) == 0) begin
          send_request(CmdLoad, d, 4'($urandom()), pick_probe(d));
        end else begin
          send_request(CmdSample, d, 4'($urandom()), pick_probe(d));
        end
      end
    end
  endtask

  // Phases of mixed traffic, each under a fresh class count.
  task automatic test_random_mix();
    logic [DistW-1:0] d;
    int phase;
    int sent;
    int r;
    for (phase = 0; phase < 6; phase++) begin
      if ($urandom_range(0, 4) == 0) begin
        write_class_count(5'($urandom_range(0, 31)));
      end else begin
        write_class_count(5'($urandom_range(1, 16)));
      end
      steady = (phase == 2);
      sent = 0;
      while (sent < PhaseItems) begin
        d = 4'($urandom());
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_request(CmdSample, d, 4'($urandom()), pick_probe(d));
          sent++;
        end else if (r < 63) begin
          load_cdf(d, ($urandom_range(0, 2) != 0) ? ShapeSorted : ShapeScrambled);
          sent += MaxClassesDef;
        end else if (r < 88) begin
          send_request(CmdLoad, d, 4'($urandom()), pick_probe(d));
          sent++;
        end else begin
          send_request(CmdSample, d, 4'($urandom()),
                       {1'($urandom_range(0, 1)), $urandom()});
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  // Take results with random stalls and compare each with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    logic [CountW-1:0] want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (drawn_class_q.size() == 0) begin
          report_mismatch($sformatf("class %0d returned with no sample request waiting",
                                    sample_class_o));
        end else begin
          want = drawn_class_q.pop_front();
          if (sample_class_o !== want) begin
            report_mismatch($sformatf("sample %0d: class %0d, predicted %0d",
                                      samples_checked, sample_class_o, want));
          end
          samples_checked++;
        end
      end
      pop <= !take_break();
    end
  end

  // Main sequence.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_tables();
    test_edge_values();
    test_class_counts();
    test_random_mix();
    push <= 1'b0;
    while (drawn_class_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    $display("Ran %0d table loads and checked %0d samples across %0d class-count writes,",
             loads_sent, samples_checked, counts_written);
    $display("including counts of zero, one, sixteen and values above sixteen.");
    if (errors == 0) begin
      $display("** discrete_inverse_cdf_sampler: PASSED **");
    end else begin
      $display("** discrete_inverse_cdf_sampler: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #6000000;
    $display("timeout with %0d samples still outstanding", drawn_class_q.size());
    $display("** discrete_inverse_cdf_sampler: FAILED **");
    $finish;
  end

endmodule
